// ===== design/pscomp_pkg.sv =====
// Shared types, constants and helpers for the pressure sensor compensation block.
`default_nettype none

package pscomp_pkg;

    localparam int RAW_W      = 24;
    localparam int CAL_W      = 16;
    localparam int DT_W       = 25;
    localparam int TEMP_OUT_W = 19;
    localparam int PRES_OUT_W = 23;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CAL_W-1:0] SENS_RST     = 16'd46546;
    localparam logic [CAL_W-1:0] OFFSET_RST   = 16'd42845;
    localparam logic [CAL_W-1:0] TCS_RST      = 16'd29751;
    localparam logic [CAL_W-1:0] TCO_RST      = 16'd29457;
    localparam logic [CAL_W-1:0] TREF_RST     = 16'd32745;
    localparam logic [CAL_W-1:0] TEMPSENS_RST = 16'd29059;

    localparam logic signed [19:0] TEMP_MID  = 20'sd2000;
    localparam logic signed [19:0] TEMP_VLOW = -20'sd1500;

    localparam logic signed [20:0] TEMP_MAX = 21'sd262143;
    localparam logic signed [20:0] TEMP_MIN = -21'sd262144;
    localparam logic signed [63:0] PRES_MAX = 64'sd4194303;
    localparam logic signed [63:0] PRES_MIN = -64'sd4194304;

    typedef enum logic [2:0] {
        REG_SENS     = 3'd0,
        REG_OFFSET   = 3'd1,
        REG_TCS      = 3'd2,
        REG_TCO      = 3'd3,
        REG_TREF     = 3'd4,
        REG_TEMPSENS = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [CAL_W-1:0] sens;
        logic [CAL_W-1:0] offset;
        logic [CAL_W-1:0] tcs;
        logic [CAL_W-1:0] tco;
        logic [CAL_W-1:0] tref;
        logic [CAL_W-1:0] tempsens;
    } cal_t;

    typedef struct packed {
        logic [RAW_W-1:0]       d1;
        logic signed [DT_W-1:0] dt;
    } entry_t;

    // signed divide by 2^k, truncating toward zero
    function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] x,
                                                     input int unsigned k);
        logic signed [63:0] bias;
        bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (x + bias) >>> k;
    endfunction

endpackage

`default_nettype wire

// ===== design/pressure_sensor_compensation.sv =====
// Top level of the pressure sensor compensation block.
//
// A conversion pair is taken when start is high and busy is low; one pair
// per cycle is sustained while busy stays low. Each transaction gives one
// result (temperature, pressure) marked by a one-cycle done strobe: after it
// is taken it passes through the front register, the queue and the
// compensation pipeline, whose length is set by the split 64-bit pressure
// product and the truncating scale steps. Results cannot be held off;
// write calibration registers only while no transaction is in flight.
`default_nettype none

module pressure_sensor_compensation
    import pscomp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ADDR_W-1:0]       paddr,
    input  wire logic [DATA_W-1:0]       pwdata,
    output logic      [DATA_W-1:0]       prdata,
    output logic                         pready,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [RAW_W-1:0]        raw_pressure,
    input  wire logic [RAW_W-1:0]        raw_temperature,
    output logic                         done,
    output logic signed [TEMP_OUT_W-1:0] temperature,
    output logic signed [PRES_OUT_W-1:0] pressure
);

    cal_t   cal;
    logic   q_full, q_empty, push;
    entry_t push_data, pop_data;

    pscomp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    pscomp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .raw_pressure    (raw_pressure),
        .raw_temperature (raw_temperature),
        .cal_tref        (cal.tref),
        .q_full          (q_full),
        .push            (push),
        .push_data       (push_data)
    );

    pscomp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (!q_empty),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    pscomp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (!q_empty),
        .in_data     (pop_data),
        .cal         (cal),
        .done        (done),
        .temperature (temperature),
        .pressure    (pressure)
    );

endmodule

`default_nettype wire

// ===== design/pscomp_cfg.sv =====
// APB calibration register file.
`default_nettype none

module pscomp_cfg
    import pscomp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cal_t                   cal
);

    cal_t     cal_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cal    = cal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg.sens     <= SENS_RST;
            cal_reg.offset   <= OFFSET_RST;
            cal_reg.tcs      <= TCS_RST;
            cal_reg.tco      <= TCO_RST;
            cal_reg.tref     <= TREF_RST;
            cal_reg.tempsens <= TEMPSENS_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SENS:     cal_reg.sens     <= pwdata[CAL_W-1:0];
                REG_OFFSET:   cal_reg.offset   <= pwdata[CAL_W-1:0];
                REG_TCS:      cal_reg.tcs      <= pwdata[CAL_W-1:0];
                REG_TCO:      cal_reg.tco      <= pwdata[CAL_W-1:0];
                REG_TREF:     cal_reg.tref     <= pwdata[CAL_W-1:0];
                REG_TEMPSENS: cal_reg.tempsens <= pwdata[CAL_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SENS:     prdata = {16'd0, cal_reg.sens};
            REG_OFFSET:   prdata = {16'd0, cal_reg.offset};
            REG_TCS:      prdata = {16'd0, cal_reg.tcs};
            REG_TCO:      prdata = {16'd0, cal_reg.tco};
            REG_TREF:     prdata = {16'd0, cal_reg.tref};
            REG_TEMPSENS: prdata = {16'd0, cal_reg.tempsens};
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/pscomp_front.sv =====
// Front end: takes a transaction and forms dT against the reference temperature.
`default_nettype none

module pscomp_front
    import pscomp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [RAW_W-1:0] raw_pressure,
    input  wire logic [RAW_W-1:0] raw_temperature,
    input  wire logic [CAL_W-1:0] cal_tref,
    input  wire logic             q_full,
    output logic                  push,
    output entry_t                push_data
);

    logic   valid_reg, valid_next;
    entry_t data_reg;
    logic   take;

    assign busy      = valid_reg && q_full;
    assign take      = start && !busy;
    assign push      = valid_reg && !q_full;
    assign push_data = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg.d1 <= raw_pressure;
            data_reg.dt <= $signed({1'b0, raw_temperature})
                         - $signed({1'b0, cal_tref, 8'd0});
        end
    end

endmodule

`default_nettype wire

// ===== design/pscomp_queue.sv =====
// Small FIFO between front end and datapath.
`default_nettype none

module pscomp_queue
    import pscomp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_data,
    input  wire logic   pop,
    output entry_t      pop_data,
    output logic        full,
    output logic        empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== design/pscomp_back.sv =====
// Compensation datapath: nine-stage pipeline from dT to saturated results.
`default_nettype none

module pscomp_back
    import pscomp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire entry_t in_data,
    input  wire cal_t   cal,
    output logic        done,
    output logic signed [TEMP_OUT_W-1:0] temperature,
    output logic signed [PRES_OUT_W-1:0] pressure
);

    logic [8:0] vld_reg;

    // stage 1: products of dT
    logic [RAW_W-1:0]    d1_s1_reg;
    logic signed [41:0]  mt_s1_reg, mo_s1_reg, ms_s1_reg;
    logic [47:0]         dtsq_s1_reg;
    logic signed [49:0]  dtsq_next;

    // stage 2: first-order terms
    logic [RAW_W-1:0]    d1_s2_reg;
    logic signed [19:0]  temp_s2_reg, temp_next;
    logic signed [35:0]  off_s2_reg, off_next;
    logic signed [34:0]  sens_s2_reg, sens_next;
    logic [17:0]         t2l_s2_reg, t2l_next;
    logic [13:0]         t2h_s2_reg, t2h_next;
    logic [49:0]         dt3;
    logic [50:0]         dt7;

    // stage 3: band decision and squares
    logic [RAW_W-1:0]    d1_s3_reg;
    logic signed [35:0]  off_s3_reg;
    logic signed [34:0]  sens_s3_reg;
    logic signed [20:0]  temp_s3_reg, temp3_next;
    logic [35:0]         devsq_s3_reg, vsq_s3_reg;
    logic                low_s3_reg, vlow_s3_reg;
    logic signed [19:0]  dev, vv;
    logic signed [39:0]  devsq_full, vsq_full;

    // stage 4: second-order corrections
    logic [RAW_W-1:0]    d1_s4_reg;
    logic signed [35:0]  off_s4_reg;
    logic signed [34:0]  sens_s4_reg;
    logic signed [20:0]  temp_s4_reg;
    logic [39:0]         off2_s4_reg, off2_next;
    logic [38:0]         sens2_s4_reg, sens2_next;
    logic [37:0]         devsq3;
    logic [38:0]         devsq5, vsq7;

    // stage 5: corrected terms, temperature saturation
    logic [RAW_W-1:0]    d1_s5_reg;
    logic signed [41:0]  offc_s5_reg;
    logic signed [40:0]  sensc_s5_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s5_reg, tsat_next;

    // stage 6: split product
    logic signed [41:0]  off_s6_reg;
    logic [43:0]         pplo_s6_reg;
    logic signed [45:0]  pphi_s6_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s6_reg;

    // stage 7: product sum
    logic signed [41:0]  off_s7_reg;
    logic signed [63:0]  prod_s7_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s7_reg;

    // stage 8: scale and remove offset
    logic signed [43:0]  q_s8_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s8_reg;

    // stage 9: output
    logic signed [PRES_OUT_W-1:0] pres_s9_reg, psat_next;
    logic signed [TEMP_OUT_W-1:0] temp_s9_reg;
    logic signed [63:0]  pdiv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[7:0], in_valid};
    end

    assign done        = vld_reg[8];
    assign temperature = temp_s9_reg;
    assign pressure    = pres_s9_reg;

    assign dtsq_next = in_data.dt * in_data.dt;

    always_ff @(posedge clk)
    begin
        d1_s1_reg   <= in_data.d1;
        mt_s1_reg   <= in_data.dt * $signed({1'b0, cal.tempsens});
        mo_s1_reg   <= in_data.dt * $signed({1'b0, cal.tco});
        ms_s1_reg   <= in_data.dt * $signed({1'b0, cal.tcs});
        dtsq_s1_reg <= dtsq_next[47:0];
    end

    always_comb
    begin
        temp_next = 20'(sdiv_pow2(64'(mt_s1_reg), 23) + 64'sd2000);
        off_next  = 36'(sdiv_pow2(64'(mo_s1_reg), 7)
                        + $signed({32'd0, cal.offset, 16'd0}));
        sens_next = 35'(sdiv_pow2(64'(ms_s1_reg), 8)
                        + $signed({33'd0, cal.sens, 15'd0}));
        dt3       = {2'b0, dtsq_s1_reg} + {1'b0, dtsq_s1_reg, 1'b0};
        dt7       = {dtsq_s1_reg, 3'b0} - {3'b0, dtsq_s1_reg};
        t2l_next  = dt3[49:32] >> 1;
        t2h_next  = dt7[50:37];
    end

    always_ff @(posedge clk)
    begin
        d1_s2_reg   <= d1_s1_reg;
        temp_s2_reg <= temp_next;
        off_s2_reg  <= off_next;
        sens_s2_reg <= sens_next;
        t2l_s2_reg  <= t2l_next;
        t2h_s2_reg  <= t2h_next;
    end

    always_comb
    begin
        dev        = temp_s2_reg - TEMP_MID;
        vv         = temp_s2_reg - TEMP_VLOW;
        devsq_full = dev * dev;
        vsq_full   = vv * vv;
        if (temp_s2_reg < TEMP_MID)
            temp3_next = 21'(temp_s2_reg) - $signed({3'b0, t2l_s2_reg});
        else
            temp3_next = 21'(temp_s2_reg) - $signed({7'b0, t2h_s2_reg});
    end

    always_ff @(posedge clk)
    begin
        d1_s3_reg    <= d1_s2_reg;
        off_s3_reg   <= off_s2_reg;
        sens_s3_reg  <= sens_s2_reg;
        temp_s3_reg  <= temp3_next;
        devsq_s3_reg <= devsq_full[35:0];
        vsq_s3_reg   <= vsq_full[35:0];
        low_s3_reg   <= (temp_s2_reg < TEMP_MID);
        vlow_s3_reg  <= (temp_s2_reg < TEMP_VLOW);
    end

    always_comb
    begin
        devsq3 = {2'b0, devsq_s3_reg} + {1'b0, devsq_s3_reg, 1'b0};
        devsq5 = {3'b0, devsq_s3_reg} + {1'b0, devsq_s3_reg, 2'b0};
        vsq7   = {vsq_s3_reg, 3'b0} - {3'b0, vsq_s3_reg};
        if (low_s3_reg)
        begin
            off2_next  = {3'b0, devsq3[37:1]}
                       + (vlow_s3_reg ? {1'b0, vsq7} : 40'd0);
            sens2_next = {3'b0, devsq5[38:3]}
                       + (vlow_s3_reg ? {1'b0, vsq_s3_reg, 2'b0} : 39'd0);
        end
        else
        begin
            off2_next  = {8'b0, devsq_s3_reg[35:4]};
            sens2_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_s4_reg    <= d1_s3_reg;
        off_s4_reg   <= off_s3_reg;
        sens_s4_reg  <= sens_s3_reg;
        temp_s4_reg  <= temp_s3_reg;
        off2_s4_reg  <= off2_next;
        sens2_s4_reg <= sens2_next;
    end

    always_comb
    begin
        if (temp_s4_reg > TEMP_MAX)
            tsat_next = TEMP_MAX[TEMP_OUT_W-1:0];
        else if (temp_s4_reg < TEMP_MIN)
            tsat_next = TEMP_MIN[TEMP_OUT_W-1:0];
        else
            tsat_next = temp_s4_reg[TEMP_OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        d1_s5_reg    <= d1_s4_reg;
        offc_s5_reg  <= 42'(off_s4_reg) - $signed({2'b0, off2_s4_reg});
        sensc_s5_reg <= 41'(sens_s4_reg) - $signed({2'b0, sens2_s4_reg});
        temp_s5_reg  <= tsat_next;
    end

    // d1 * SENS as low and high partial products
    always_ff @(posedge clk)
    begin
        off_s6_reg  <= offc_s5_reg;
        temp_s6_reg <= temp_s5_reg;
        pplo_s6_reg <= d1_s5_reg * sensc_s5_reg[19:0];
        pphi_s6_reg <= $signed({1'b0, d1_s5_reg}) * $signed(sensc_s5_reg[40:20]);
    end

    always_ff @(posedge clk)
    begin
        off_s7_reg  <= off_s6_reg;
        temp_s7_reg <= temp_s6_reg;
        prod_s7_reg <= (64'(pphi_s6_reg) <<< 20) + $signed({20'd0, pplo_s6_reg});
    end

    always_ff @(posedge clk)
    begin
        temp_s8_reg <= temp_s7_reg;
        q_s8_reg    <= 44'(sdiv_pow2(prod_s7_reg, 21) - 64'(off_s7_reg));
    end

    always_comb
    begin
        pdiv = sdiv_pow2(64'(q_s8_reg), 15);
        if (pdiv > PRES_MAX)
            psat_next = PRES_MAX[PRES_OUT_W-1:0];
        else if (pdiv < PRES_MIN)
            psat_next = PRES_MIN[PRES_OUT_W-1:0];
        else
            psat_next = pdiv[PRES_OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        temp_s9_reg <= temp_s8_reg;
        pres_s9_reg <= psat_next;
    end

endmodule

`default_nettype wire

// ===== tb/tb_pressure_sensor_compensation.sv =====
// Testbench for the pressure sensor compensation block: predictor, stimulus and result checker.
`default_nettype none

module tb_pressure_sensor_compensation
    import pscomp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 11;
    localparam longint CYCLE_LIMIT = 400000;

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [ADDR_W-1:0]            paddr;
    logic [DATA_W-1:0]            pwdata;
    logic [DATA_W-1:0]            prdata;
    logic                         pready;
    logic                         start;
    logic                         busy;
    logic [RAW_W-1:0]             raw_pressure;
    logic [RAW_W-1:0]             raw_temperature;
    logic                         done;
    logic signed [TEMP_OUT_W-1:0] temperature;
    logic signed [PRES_OUT_W-1:0] pressure;

    typedef struct {
        logic signed [TEMP_OUT_W-1:0] temp;
        logic signed [PRES_OUT_W-1:0] pres;
    } reading_t;

    reading_t   pending_readings[$];
    cal_t       cal;
    int         mismatch_count;
    longint     cycle_count;

    pressure_sensor_compensation u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .raw_pressure(raw_pressure), .raw_temperature(raw_temperature),
        .done(done), .temperature(temperature), .pressure(pressure)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // truncating divide by 2^k
    function automatic longint trunc_shift(longint x, int k);
        longint d;
        d = longint'(1) << k;
        return x / d;
    endfunction

    function automatic reading_t compensate(logic [RAW_W-1:0] d1_raw,
                                            logic [RAW_W-1:0] d2_raw);
        longint d1, dt, tmp, off, sns, t2, off2, sns2, dev, v, p;
        reading_t r;
        d1 = longint'(d1_raw);
        dt = longint'(d2_raw) - longint'(cal.tref) * 256;
        tmp = 2000 + trunc_shift(dt * longint'(cal.tempsens), 23);
        off = longint'(cal.offset) * 65536 + trunc_shift(longint'(cal.tco) * dt, 7);
        sns = longint'(cal.sens) * 32768 + trunc_shift(longint'(cal.tcs) * dt, 8);
        dev = tmp - 2000;
        if (tmp < 2000)
        begin
            t2 = trunc_shift(3 * dt * dt, 33);
            off2 = trunc_shift(3 * dev * dev, 1);
            sns2 = trunc_shift(5 * dev * dev, 3);
            if (tmp < -1500)
            begin
                v = tmp + 1500;
                off2 += 7 * v * v;
                sns2 += 4 * v * v;
            end
        end
        else
        begin
            t2 = trunc_shift(7 * dt * dt, 37);
            off2 = trunc_shift(dev * dev, 4);
            sns2 = 0;
        end
        tmp -= t2;
        off -= off2;
        sns -= sns2;
        p = trunc_shift(trunc_shift(d1 * sns, 21) - off, 15);
        if (tmp < -262144) tmp = -262144;
        if (tmp > 262143) tmp = 262143;
        if (p < -4194304) p = -4194304;
        if (p > 4194303) p = 4194303;
        r.temp = tmp[TEMP_OUT_W-1:0];
        r.pres = p[PRES_OUT_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_pressure_sensor_compensation: done, errors");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        reading_t exp_r;
        if (rst_n && done)
        begin
            if (pending_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: temp %0d pres %0d", temperature, pressure);
            end
            else
            begin
                exp_r = pending_readings.pop_front();
                if (exp_r.temp !== temperature || exp_r.pres !== pressure)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: temp exp %0d got %0d, pres exp %0d got %0d",
                                 exp_r.temp, temperature, exp_r.pres, pressure);
                end
            end
        end
    end

    task automatic write_cal(reg_idx_t idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SENS:     cal.sens = value[CAL_W-1:0];
            REG_OFFSET:   cal.offset = value[CAL_W-1:0];
            REG_TCS:      cal.tcs = value[CAL_W-1:0];
            REG_TCO:      cal.tco = value[CAL_W-1:0];
            REG_TREF:     cal.tref = value[CAL_W-1:0];
            REG_TEMPSENS: cal.tempsens = value[CAL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all_cal(logic [CAL_W-1:0] s, logic [CAL_W-1:0] o,
                                 logic [CAL_W-1:0] tcs, logic [CAL_W-1:0] tco,
                                 logic [CAL_W-1:0] tref, logic [CAL_W-1:0] ts);
        write_cal(REG_SENS, {16'($urandom_range(0, 65535)), s});
        write_cal(REG_OFFSET, {16'h0, o});
        write_cal(REG_TCS, {16'h0, tcs});
        write_cal(REG_TCO, {16'h0, tco});
        write_cal(REG_TREF, {16'h0, tref});
        write_cal(REG_TEMPSENS, {16'h0, ts});
    endtask

    // send one conversion pair; gap drawn per transaction
    task automatic send_pair(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2, bit use_gap);
        int gap;
        gap = use_gap ? $urandom_range(0, 17) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        raw_pressure <= d1;
        raw_temperature <= d2;
        do @(posedge clk); while (busy);
        pending_readings.push_back(compensate(d1, d2));
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic test_directed;
        logic [RAW_W-1:0] edges[6];
        edges = '{24'd0, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'd8382720, 24'h555555};
        foreach (edges[i])
            foreach (edges[j])
                if (i < 4 || j < 4)
                    send_pair(edges[i], edges[j], 1'b0);
        drain();
    endtask

    task automatic test_bands;
        // temperatures around the band edges: high, low, very low
        int d2;
        for (int k = 0; k < 300; k++)
        begin
            d2 = int'(cal.tref) * 256 + $signed($urandom_range(0, 2000000)) - 1000000;
            if (d2 < 0) d2 = 0;
            if (d2 > 16777215) d2 = 16777215;
            send_pair(RAW_W'($urandom()), RAW_W'(d2), ($urandom_range(0, 3) == 0));
        end
        drain();
    endtask

    task automatic test_random(int n, bit gaps);
        for (int k = 0; k < n; k++)
        begin
            send_pair(RAW_W'($urandom()), RAW_W'($urandom()), gaps);
            if (k == n / 2)
            begin
                // hold off until everything in flight has come back
                start <= 1'b0;
                @(posedge clk);
                while (pending_readings.size() != 0) @(posedge clk);
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        raw_pressure = '0;
        raw_temperature = '0;
        mismatch_count = 0;
        cycle_count = 0;
        cal = '{SENS_RST, OFFSET_RST, TCS_RST, TCO_RST, TREF_RST, TEMPSENS_RST};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_bands();
        test_random(100, 1'b1);
        write_all_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_directed();
        test_random(90, 1'b1);
        write_all_cal(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        test_random(100, 1'b0);
        write_all_cal(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                      16'($urandom()), 16'($urandom()));
        test_bands();
        test_random(200, 1'b1);
        write_all_cal(16'd46546, 16'd42845, 16'd29751, 16'd29457, 16'd32745, 16'hFFFF);
        test_bands();
        test_random(100, 1'b0);

        if (mismatch_count == 0)
            $display("tb_pressure_sensor_compensation: done, clean");
        else
            $display("tb_pressure_sensor_compensation: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
design/pscomp_pkg.sv
design/pscomp_cfg.sv
design/pscomp_front.sv
design/pscomp_queue.sv
design/pscomp_back.sv
design/pressure_sensor_compensation.sv
tb/tb_pressure_sensor_compensation.sv
